// ===== rtl/ray_triangle_intersect_unit_assert.svh =====
// Assertion macros shared by the ray / triangle unit
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RTI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTI_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define RTI_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RTI_ASSERT(name, clk, rst_n, prop, msg)
`define RTI_ASSERT_IMP(name, clk, rst_n, pre, post, msg)
`define RTI_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/rti_pkg.sv =====
package rti_pkg;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned THRESH_W   = 40;
  localparam int unsigned DIST_W     = 31;
  localparam int unsigned QUOT_W     = 31;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 40'd281474977;
  localparam logic [DIST_W-1:0]   DIST_SAT     = 31'h7FFF_FFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_ORIGIN_Z      = 3'd2,
    CFG_DIRECTION_X   = 3'd3,
    CFG_DIRECTION_Y   = 3'd4,
    CFG_DIRECTION_Z   = 3'd5,
    CFG_DET_THRESHOLD = 3'd6
  } cfg_idx_e;

  // control travelling from the geometry pipe into the divider
  typedef struct packed {
    logic valid;
    logic pass;
    logic sat;
  } rti_ctl_t;

endpackage

// ===== rtl/rti_front.sv =====
`include "ray_triangle_intersect_unit_assert.svh"
module rti_front #(
  parameter int unsigned COORD_WIDTH = 32,
  localparam int unsigned EW = COORD_WIDTH + 1,
  localparam int unsigned PW = 2 * EW + 1,
  localparam int unsigned DW = 3 * EW + 3,
  localparam int unsigned RW = DW + 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rti_pkg::FIELD_W-1:0]        vtx_i [9],
  input  logic [rti_pkg::FIELD_W-1:0]        org_i [3],
  input  logic [rti_pkg::FIELD_W-1:0]        dir_i [3],
  input  logic [rti_pkg::THRESH_W-1:0]       thresh_i,
  output rti_pkg::rti_ctl_t                  ctl_o,
  input  logic                               out_ready_i,
  output logic [RW-1:0]                      num_o,
  output logic [RW-1:0]                      den_o
);

  localparam int unsigned NS = 8;
  localparam int unsigned MW = 2 * EW;
  localparam int unsigned HW = 2 * EW + 1;

  logic [NS-1:0] v_q, rdy, v_in;

  // ready chain: a stage loads when empty or when the next one moves
  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign v_in       = {v_q[NS-2:0], in_valid_i};
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (rdy & v_in) | (~rdy & v_q);
    end
  end

  // stage 1: edges, origin offset, direction
  logic signed [EW-1:0] e1_d [3], e2_d [3], tv_d [3], dr_d [3];
  logic signed [EW-1:0] e1_1q [3], e2_1q [3], tv_1q [3], dr_1q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = EW'($signed(vtx_i[3+i][COORD_WIDTH-1:0]))
              - EW'($signed(vtx_i[i][COORD_WIDTH-1:0]));
      e2_d[i] = EW'($signed(vtx_i[6+i][COORD_WIDTH-1:0]))
              - EW'($signed(vtx_i[i][COORD_WIDTH-1:0]));
      tv_d[i] = EW'($signed(org_i[i][COORD_WIDTH-1:0]))
              - EW'($signed(vtx_i[i][COORD_WIDTH-1:0]));
      dr_d[i] = EW'($signed(dir_i[i][COORD_WIDTH-1:0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      e1_1q <= e1_d;
      e2_1q <= e2_d;
      tv_1q <= tv_d;
      dr_1q <= dr_d;
    end
  end

  // stage 2: cross product terms
  logic signed [MW-1:0] pm_d [6], qm_d [6], pm_q [6], qm_q [6];
  logic signed [EW-1:0] e1_2q [3], e2_2q [3], tv_2q [3], dr_2q [3];

  always_comb begin
    pm_d[0] = dr_1q[1] * e2_1q[2];
    pm_d[1] = dr_1q[2] * e2_1q[1];
    pm_d[2] = dr_1q[2] * e2_1q[0];
    pm_d[3] = dr_1q[0] * e2_1q[2];
    pm_d[4] = dr_1q[0] * e2_1q[1];
    pm_d[5] = dr_1q[1] * e2_1q[0];
    qm_d[0] = tv_1q[1] * e1_1q[2];
    qm_d[1] = tv_1q[2] * e1_1q[1];
    qm_d[2] = tv_1q[2] * e1_1q[0];
    qm_d[3] = tv_1q[0] * e1_1q[2];
    qm_d[4] = tv_1q[0] * e1_1q[1];
    qm_d[5] = tv_1q[1] * e1_1q[0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pm_q  <= pm_d;
      qm_q  <= qm_d;
      e1_2q <= e1_1q;
      e2_2q <= e2_1q;
      tv_2q <= tv_1q;
      dr_2q <= dr_1q;
    end
  end

  // stage 3: finish pvec and qvec
  logic signed [PW-1:0] pv_d [3], qv_d [3], pv_q [3], qv_q [3];
  logic signed [EW-1:0] e1_3q [3], e2_3q [3], tv_3q [3], dr_3q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv_d[i] = PW'(pm_q[2*i]) - PW'(pm_q[2*i+1]);
      qv_d[i] = PW'(qm_q[2*i]) - PW'(qm_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      pv_q  <= pv_d;
      qv_q  <= qv_d;
      e1_3q <= e1_2q;
      e2_3q <= e2_2q;
      tv_3q <= tv_2q;
      dr_3q <= dr_2q;
    end
  end

  // stage 4: dot product partials, wide operand split in low and high halves
  // dots: det = e1.pv, U = tv.pv, V = dir.qv, T = e2.qv
  logic signed [EW-1:0] dav [4][3];
  logic signed [PW-1:0] dbv [4][3];
  logic signed [EW:0]   lo_w [4][3], hi_w [4][3];
  logic signed [HW-1:0] pl_d [4][3], ph_d [4][3], pl_q [4][3], ph_q [4][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dav[0][j] = e1_3q[j];
      dbv[0][j] = pv_q[j];
      dav[1][j] = tv_3q[j];
      dbv[1][j] = pv_q[j];
      dav[2][j] = dr_3q[j];
      dbv[2][j] = qv_q[j];
      dav[3][j] = e2_3q[j];
      dbv[3][j] = qv_q[j];
    end
    for (int d = 0; d < 4; d++) begin
      for (int j = 0; j < 3; j++) begin
        lo_w[d][j] = $signed({1'b0, dbv[d][j][EW-1:0]});
        hi_w[d][j] = $signed(dbv[d][j][PW-1:EW]);
        pl_d[d][j] = dav[d][j] * lo_w[d][j];
        ph_d[d][j] = dav[d][j] * hi_w[d][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
  end

  // stage 5: rebuild each product from its halves
  logic signed [DW-1:0] tm_d [4][3], tm_q [4][3];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      for (int j = 0; j < 3; j++) begin
        tm_d[d][j] = (DW'(ph_q[d][j]) <<< EW) + DW'(pl_q[d][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      tm_q <= tm_d;
    end
  end

  // stage 6: sum the three terms of each dot product
  logic signed [DW-1:0] dot_d [4], dot_q [4];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      dot_d[d] = tm_q[d][0] + tm_q[d][1] + tm_q[d][2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      dot_q <= dot_d;
    end
  end

  // stage 7: flip all four signs when det is negative
  logic signed [DW-1:0] nrm_d [4], nrm_q [4];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nrm_d[d] = dot_q[0][DW-1] ? -dot_q[d] : dot_q[d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      nrm_q <= nrm_d;
    end
  end

  // stage 8: barycentric and distance tests, set up the division
  logic signed [DW-1:0] thr_ext;
  logic signed [DW:0]   uv_sum;
  logic                 pass_d, pass_q, sat_d, sat_q;
  logic [RW-1:0]        num_d, den_d, num_q, den_q;

  always_comb begin
    thr_ext = $signed(DW'(thresh_i));
    uv_sum  = (DW+1)'(nrm_q[1]) + (DW+1)'(nrm_q[2]);
    pass_d  = !(nrm_q[0] < thr_ext)
           && !nrm_q[1][DW-1] && !(nrm_q[1] > nrm_q[0])
           && !nrm_q[2][DW-1] && !(uv_sum > (DW+1)'(nrm_q[0]))
           && (nrm_q[3] > $signed(DW'(0)));
    num_d   = RW'(nrm_q[3][DW-1:0]) << rti_pkg::FRAC_W;
    den_d   = RW'(nrm_q[0][DW-1:0]);
    sat_d   = num_d >= (den_d << rti_pkg::QUOT_W);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      pass_q <= pass_d;
      sat_q  <= sat_d;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  assign ctl_o.valid = v_q[NS-1];
  assign ctl_o.pass  = pass_q;
  assign ctl_o.sat   = sat_q;
  assign num_o       = num_q;
  assign den_o       = den_q;

  `RTI_ASSERT_NEXT(a_front_hold, clk_i, rst_ni, v_q[NS-1] && !out_ready_i, v_q[NS-1],
    "front: stalled word dropped")
  `RTI_ASSERT_IMP(a_front_ready, clk_i, rst_ni, !v_q[NS-1], rdy == {NS{1'b1}} || v_q != '0,
    "front: ready chain blocked with empty tail")

endmodule

// ===== rtl/rti_div.sv =====
`include "ray_triangle_intersect_unit_assert.svh"
module rti_div #(
  parameter int unsigned RW = 134
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rti_pkg::rti_ctl_t             ctl_i,
  output logic                          in_ready_o,
  input  logic [RW-1:0]                 num_i,
  input  logic [RW-1:0]                 den_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [rti_pkg::DIST_W-1:0]    dist_o
);

  localparam int unsigned QW = rti_pkg::QUOT_W;
  localparam int unsigned NS = QW + 1;

  logic [NS-1:0] v_q, rdy, v_in;

  // ready chain over the quotient stages and the output register
  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign v_in       = {v_q[NS-2:0], ctl_i.valid};
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (rdy & v_in) | (~rdy & v_q);
    end
  end

  // restoring division, one quotient bit per stage, top bit first
  logic [RW-1:0] rem_q [QW];
  logic [RW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          pass_q [QW];
  logic          sat_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned K = QW - 1 - s;
    logic [RW-1:0] rem_p, den_p, sub_w, rem_d;
    logic [QW-1:0] quo_p, quo_d;
    logic          pass_p, sat_p, ge;

    if (s == 0) begin : g_first
      assign rem_p  = num_i;
      assign den_p  = den_i;
      assign quo_p  = '0;
      assign pass_p = ctl_i.pass;
      assign sat_p  = ctl_i.sat;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign den_p  = den_q[s-1];
      assign quo_p  = quo_q[s-1];
      assign pass_p = pass_q[s-1];
      assign sat_p  = sat_q[s-1];
    end

    always_comb begin
      sub_w    = den_p << K;
      ge       = rem_p >= sub_w;
      rem_d    = ge ? rem_p - sub_w : rem_p;
      quo_d    = quo_p;
      quo_d[K] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_p;
        quo_q[s]  <= quo_d;
        pass_q[s] <= pass_p;
        sat_q[s]  <= sat_p;
      end
    end
  end

  // output register: hit needs t of at least one LSB
  logic                       hit_d, hit_q;
  logic [rti_pkg::DIST_W-1:0] dist_d, dist_q;

  always_comb begin
    hit_d = pass_q[QW-1] && (sat_q[QW-1] || (quo_q[QW-1] != '0));
    if (!hit_d) begin
      dist_d = '0;
    end else if (sat_q[QW-1]) begin
      dist_d = rti_pkg::DIST_SAT;
    end else begin
      dist_d = quo_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign hit_o       = hit_q;
  assign dist_o      = dist_q;

  `RTI_ASSERT_IMP(a_div_hit_dist, clk_i, rst_ni, out_valid_o && hit_o, dist_o != '0,
    "div: hit with zero distance")
  `RTI_ASSERT_IMP(a_div_miss_dist, clk_i, rst_ni, out_valid_o && !hit_o, dist_o == '0,
    "div: miss with nonzero distance")

endmodule

// ===== rtl/ray_triangle_intersect_unit.sv =====
// Channel  | Handshake                 | Word
// ---------+---------------------------+----------------------------------------
// input    | in_valid_i / in_ready_o   | a_*_i, b_*_i, c_*_i vertex coordinates
// output   | out_valid_o / out_ready_i | hit_o, hit_distance_o
// config   | cfg_we_i                  | cfg_addr_i, cfg_wdata_i (no wait)
//
// One triangle word enters per cycle unless a stall holds the pipe; each word passes
// through 8 geometry stages, 31 quotient stages and 1 output register.
// The 31-stage restoring divider for t is the longest part of the pipe.
// A stall holds only the stages behind the stalled one; bubbles still close up.
// Reset clears all stage valid bits and loads the ray registers with zero
// and the determinant threshold with its default.
`include "ray_triangle_intersect_unit_assert.svh"
module ray_triangle_intersect_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rti_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [rti_pkg::THRESH_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rti_pkg::FIELD_W-1:0]       a_x_i,
  input  logic [rti_pkg::FIELD_W-1:0]       a_y_i,
  input  logic [rti_pkg::FIELD_W-1:0]       a_z_i,
  input  logic [rti_pkg::FIELD_W-1:0]       b_x_i,
  input  logic [rti_pkg::FIELD_W-1:0]       b_y_i,
  input  logic [rti_pkg::FIELD_W-1:0]       b_z_i,
  input  logic [rti_pkg::FIELD_W-1:0]       c_x_i,
  input  logic [rti_pkg::FIELD_W-1:0]       c_y_i,
  input  logic [rti_pkg::FIELD_W-1:0]       c_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [rti_pkg::DIST_W-1:0]        hit_distance_o
);

  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned RW = 3 * EW + 3 + 32;

  // ray registers
  logic [rti_pkg::FIELD_W-1:0]  org_q [3];
  logic [rti_pkg::FIELD_W-1:0]  dir_q [3];
  logic [rti_pkg::THRESH_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '{default: '0};
      dir_q <= '{default: '0};
      thr_q <= rti_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      case (rti_pkg::cfg_idx_e'(cfg_addr_i))
        rti_pkg::CFG_ORIGIN_X:      org_q[0] <= cfg_wdata_i[rti_pkg::FIELD_W-1:0];
        rti_pkg::CFG_ORIGIN_Y:      org_q[1] <= cfg_wdata_i[rti_pkg::FIELD_W-1:0];
        rti_pkg::CFG_ORIGIN_Z:      org_q[2] <= cfg_wdata_i[rti_pkg::FIELD_W-1:0];
        rti_pkg::CFG_DIRECTION_X:   dir_q[0] <= cfg_wdata_i[rti_pkg::FIELD_W-1:0];
        rti_pkg::CFG_DIRECTION_Y:   dir_q[1] <= cfg_wdata_i[rti_pkg::FIELD_W-1:0];
        rti_pkg::CFG_DIRECTION_Z:   dir_q[2] <= cfg_wdata_i[rti_pkg::FIELD_W-1:0];
        rti_pkg::CFG_DET_THRESHOLD: thr_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [rti_pkg::FIELD_W-1:0] vtx [9];

  assign vtx[0] = a_x_i;
  assign vtx[1] = a_y_i;
  assign vtx[2] = a_z_i;
  assign vtx[3] = b_x_i;
  assign vtx[4] = b_y_i;
  assign vtx[5] = b_z_i;
  assign vtx[6] = c_x_i;
  assign vtx[7] = c_y_i;
  assign vtx[8] = c_z_i;

  rti_pkg::rti_ctl_t ctl;
  logic              div_ready;
  logic [RW-1:0]     num, den;

  rti_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .vtx_i       (vtx),
    .org_i       (org_q),
    .dir_i       (dir_q),
    .thresh_i    (thr_q),
    .ctl_o       (ctl),
    .out_ready_i (div_ready),
    .num_o       (num),
    .den_o       (den)
  );

  rti_div #(
    .RW (RW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_ready_o  (div_ready),
    .num_i       (num),
    .den_i       (den),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .dist_o      (hit_distance_o)
  );

  `RTI_ASSERT_IMP(a_top_ready, clk_i, rst_ni, !out_valid_o, in_ready_o,
    "top: input blocked while output register is empty")

endmodule
